### hdl/pcms_pkg.sv
// Shared types, constants and helper functions for the candidate mismatch scorer.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package pcms_pkg;

	localparam int SCORE_BITS_DEF = 32;
	localparam int WORD_BITS      = 64;
	localparam int THR_BITS       = 25;
	localparam int K_BITS         = 24;
	localparam int WEIGHT_BITS    = 6;
	localparam int OUT_SCORE_BITS = 32;
	localparam int MODE_BITS      = 3;
	localparam int ADDR_BITS      = 5;
	localparam int REG_IDX_BITS   = 2;

	// xoroshiro128 step and ++ scrambler rotations
	localparam int unsigned ROT_A    = 49;
	localparam int unsigned SHIFT_B  = 21;
	localparam int unsigned ROT_C    = 28;
	localparam int unsigned ROT_OUT  = 17;

	localparam logic [WEIGHT_BITS-1:0] WEIGHT_UNIT  = 6'd1;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_HEAVY = 6'd50;

	// register indexes, taken from paddr[4:3]
	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_SEED_LOW  = 2'd0,
		REG_SEED_HIGH = 2'd1,
		REG_MODE      = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	localparam logic [MODE_BITS-1:0] MODE_RESET    = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_ONE_STEP = 3'd4;
	localparam logic [MODE_BITS-1:0] MODE_TWO_STEP = 3'd5;

	typedef struct packed {
		logic [WORD_BITS-1:0] seed_low;
		logic [WORD_BITS-1:0] seed_high;
		logic [MODE_BITS-1:0] mode;
	} cfg_t;

	// per-item control carried alongside the generator output
	typedef struct packed {
		logic [THR_BITS-1:0] threshold;
		logic                observed;
		logic                last;
		logic                scored;
		logic                heavy;
	} item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] s0;
		logic [WORD_BITS-1:0] s1;
	} xoro_state_t;

	function automatic logic [WORD_BITS-1:0] rotl64(input logic [WORD_BITS-1:0] v,
			input int unsigned r);
		rotl64 = (v << r) | (v >> (WORD_BITS - r));
	endfunction

	function automatic xoro_state_t xoro_step(input xoro_state_t st);
		logic [WORD_BITS-1:0] x;
		x = st.s0 ^ st.s1;
		xoro_step.s0 = rotl64(st.s0, ROT_A) ^ x ^ (x << SHIFT_B);
		xoro_step.s1 = rotl64(x, ROT_C);
	endfunction

endpackage

### hdl/pcms_regs.sv
// APB-style configuration registers: candidate seed halves and scoring mode.
// Depends on pcms_pkg.
`timescale 1ns / 1ps

module pcms_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pcms_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [pcms_pkg::WORD_BITS-1:0]  pwdata,
	output logic [pcms_pkg::WORD_BITS-1:0]  prdata,
	output logic                            pready,
	output pcms_pkg::cfg_t                  cfg
);
	import pcms_pkg::*;

	logic [WORD_BITS-1:0] seed_low_q;
	logic [WORD_BITS-1:0] seed_high_q;
	logic [MODE_BITS-1:0] mode_q;
	logic                 wr_en;
	reg_idx_t             idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:ADDR_BITS-REG_IDX_BITS]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q  <= '0;
			seed_high_q <= '0;
			mode_q      <= MODE_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_SEED_LOW:  seed_low_q  <= pwdata;
				REG_SEED_HIGH: seed_high_q <= pwdata;
				REG_MODE:      mode_q      <= pwdata[MODE_BITS-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SEED_LOW:  prdata = seed_low_q;
			REG_SEED_HIGH: prdata = seed_high_q;
			REG_MODE:      prdata = WORD_BITS'(mode_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.seed_low  = seed_low_q;
	assign cfg.seed_high = seed_high_q;
	assign cfg.mode      = mode_q;

endmodule

### hdl/pcms_gen.sv
// Input register and generator stage: xoroshiro steps, seed mix and the first
// half of the ++ scrambler (add and rotate). Depends on pcms_pkg.
`timescale 1ns / 1ps

module pcms_gen (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pcms_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pcms_pkg::WORD_BITS-1:0]  position_seed,
	input  logic [pcms_pkg::THR_BITS-1:0]   threshold,
	input  logic                            observed,
	input  logic                            last_item,
	output logic                            gen_valid,
	input  logic                            gen_ready,
	output logic [pcms_pkg::WORD_BITS-1:0]  rot_sum,
	output logic [pcms_pkg::WORD_BITS-1:0]  mix_low,
	output pcms_pkg::item_t                 item
);
	import pcms_pkg::*;

	logic                 valid_s1;
	logic [WORD_BITS-1:0] pos_s1;
	logic [THR_BITS-1:0]  thr_s1;
	logic                 obs_s1;
	logic                 last_s1;

	logic                 valid_s2;
	logic [WORD_BITS-1:0] rot_s2;
	logic [WORD_BITS-1:0] lo_s2;
	item_t                item_s2;

	logic                 adv_s1;
	logic                 adv_s2;
	xoro_state_t          st_zero;
	xoro_state_t          st_one;
	xoro_state_t          st_two;
	xoro_state_t          st_sel;
	logic [WORD_BITS-1:0] lo;
	logic [WORD_BITS-1:0] hi;
	logic [WORD_BITS-1:0] sum;
	item_t                item_d;

	assign adv_s2   = !valid_s2 || gen_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			pos_s1  <= position_seed;
			thr_s1  <= threshold;
			obs_s1  <= observed;
			last_s1 <= last_item;
		end
	end

	// state pair starts as (position_seed, 0) and takes 0, 1 or 2 steps
	always_comb begin
		st_zero.s0 = pos_s1;
		st_zero.s1 = '0;
		st_one     = xoro_step(st_zero);
		st_two     = xoro_step(st_one);
		case (cfg.mode)
			MODE_ONE_STEP: st_sel = st_one;
			MODE_TWO_STEP: st_sel = st_two;
			default:       st_sel = st_zero;
		endcase
		lo  = cfg.seed_low ^ st_sel.s0;
		hi  = cfg.seed_high ^ st_sel.s1;
		sum = lo + hi;

		item_d.threshold = thr_s1;
		item_d.observed  = obs_s1;
		item_d.last      = last_s1;
		item_d.scored    = (cfg.mode <= MODE_TWO_STEP);
		item_d.heavy     = (cfg.mode == MODE_TWO_STEP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rot_s2  <= rotl64(sum, ROT_OUT);
			lo_s2   <= lo;
			item_s2 <= item_d;
		end
	end

	assign gen_valid = valid_s2;
	assign rot_sum   = rot_s2;
	assign mix_low   = lo_s2;
	assign item      = item_s2;

endmodule

### hdl/pcms_score.sv
// Prediction, mismatch weighting and the saturating score accumulator, ending
// in the result register. Depends on pcms_pkg.
`timescale 1ns / 1ps

module pcms_score #(
	parameter int SCORE_BITS = pcms_pkg::SCORE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 gen_valid,
	output logic                                 gen_ready,
	input  logic [pcms_pkg::WORD_BITS-1:0]       rot_sum,
	input  logic [pcms_pkg::WORD_BITS-1:0]       mix_low,
	input  pcms_pkg::item_t                      item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 mismatch,
	output logic [pcms_pkg::WEIGHT_BITS-1:0]     added_weight,
	output logic [pcms_pkg::OUT_SCORE_BITS-1:0]  running_score,
	output logic                                 last_result
);
	import pcms_pkg::*;

	localparam int SUM_BITS = SCORE_BITS + 1;

	logic                   valid_s3;
	logic                   mis_s3;
	logic [WEIGHT_BITS-1:0] weight_s3;
	logic                   last_s3;

	logic                      valid_q;
	logic                      mis_q;
	logic [WEIGHT_BITS-1:0]    weight_q;
	logic [OUT_SCORE_BITS-1:0] score_q;
	logic                      last_q;
	logic [SCORE_BITS-1:0]     acc_q;

	logic                   adv_s3;
	logic                   load;
	logic [WORD_BITS-1:0]   gen;
	logic                   pred;
	logic                   mis_d;
	logic [WEIGHT_BITS-1:0] weight_d;
	logic [SUM_BITS-1:0]    acc_sum;
	logic [SCORE_BITS-1:0]  acc_next;

	assign load      = valid_s3 && (!valid_q || out_ready);
	assign adv_s3    = !valid_s3 || load;
	assign gen_ready = adv_s3;

	// finish the ++ output and compare its top bits with the threshold
	always_comb begin
		gen      = rot_sum + mix_low;
		pred     = ({1'b0, gen[WORD_BITS-1 -: K_BITS]} < item.threshold);
		mis_d    = item.scored & (pred ^ item.observed);
		weight_d = '0;
		if (mis_d) begin
			weight_d = (item.heavy && item.observed) ? WEIGHT_HEAVY : WEIGHT_UNIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= gen_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && gen_valid) begin
			mis_s3    <= mis_d;
			weight_s3 <= weight_d;
			last_s3   <= item.last;
		end
	end

	// saturate on carry out of the accumulator width
	always_comb begin
		acc_sum = {1'b0, acc_q} + SUM_BITS'(weight_s3);
		if (acc_sum[SCORE_BITS]) begin
			acc_next = '1;
		end else begin
			acc_next = acc_sum[SCORE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				acc_q   <= last_s3 ? '0 : acc_next;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mis_q    <= mis_s3;
			weight_q <= weight_s3;
			score_q  <= OUT_SCORE_BITS'(acc_next);
			last_q   <= last_s3;
		end
	end

	assign out_valid     = valid_q;
	assign mismatch      = mis_q;
	assign added_weight  = weight_q;
	assign running_score = score_q;
	assign last_result   = last_q;

	a_weight_needs_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && weight_q != '0) |-> mis_q)
		else $error("weight emitted without a mismatch");

	a_weight_codes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (weight_q == '0 || weight_q == WEIGHT_UNIT || weight_q == WEIGHT_HEAVY))
		else $error("weight is not 0, 1 or 50");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_s3) |=> (acc_q == '0))
		else $error("score not cleared after last result");

	a_acc_tracks_score: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !last_s3) |=> (score_q == OUT_SCORE_BITS'(acc_q)))
		else $error("emitted score differs from accumulator");

endmodule

### hdl/prng_candidate_mismatch_score_unit.sv
// Top level of the candidate mismatch scorer: configuration registers, generator
// stage and scoring stage. Depends on pcms_pkg, pcms_regs, pcms_gen, pcms_score.
`timescale 1ns / 1ps

// Scores one 128-bit xoroshiro128++ candidate seed against a stream of
// observations. Each transfer on s_* carries a position seed, a 1.24 threshold
// and an observed bit; one result per observation leaves on m_* with the
// mismatch flag, the weight added and the saturating running score, which
// clears after the result marked tlast. One observation is taken every cycle
// while m_tready does not hold the output back; each observation passes
// through the input, generator, compare and result registers in that order,
// and the accumulator update at the result register sets that rate.
// Seed and mode are written through the APB port at byte addresses 0, 8 and 16;
// the user must write them only while no observation is in flight, as the
// block itself does not enforce this.
module prng_candidate_mismatch_score_unit #(
	parameter int SCORE_BITS = pcms_pkg::SCORE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pcms_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [pcms_pkg::WORD_BITS-1:0]  pwdata,
	output logic [pcms_pkg::WORD_BITS-1:0]  prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [63:0] position_seed, [88:64] threshold, [89] observed, [95:90] zero
	input  logic [95:0]                     s_tdata,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] mismatch, [6:1] added_weight, [38:7] running_score, [39] zero
	output logic [39:0]                     m_tdata,
	output logic                            m_tlast
);
	import pcms_pkg::*;

	cfg_t                      cfg;
	logic                      gen_valid;
	logic                      gen_ready;
	logic [WORD_BITS-1:0]      rot_sum;
	logic [WORD_BITS-1:0]      mix_low;
	item_t                     item;
	logic                      mismatch;
	logic [WEIGHT_BITS-1:0]    added_weight;
	logic [OUT_SCORE_BITS-1:0] running_score;

	pcms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pcms_gen u_gen (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.position_seed (s_tdata[63:0]),
		.threshold     (s_tdata[88:64]),
		.observed      (s_tdata[89]),
		.last_item     (s_tlast),
		.gen_valid     (gen_valid),
		.gen_ready     (gen_ready),
		.rot_sum       (rot_sum),
		.mix_low       (mix_low),
		.item          (item)
	);

	pcms_score #(
		.SCORE_BITS (SCORE_BITS)
	) u_score (
		.clk           (clk),
		.arst_n        (arst_n),
		.gen_valid     (gen_valid),
		.gen_ready     (gen_ready),
		.rot_sum       (rot_sum),
		.mix_low       (mix_low),
		.item          (item),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.mismatch      (mismatch),
		.added_weight  (added_weight),
		.running_score (running_score),
		.last_result   (m_tlast)
	);

	assign m_tdata = {1'b0, running_score, added_weight, mismatch};

endmodule
